// ===== design/jse_pkg.sv =====
package jse_pkg;

   // queue between classifier and serializer
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // result characters
   localparam logic [7:0] CharQuote  = 8'h22;
   localparam logic [7:0] CharBslash = 8'h5C;
   localparam logic [7:0] CharLowerU = 8'h75;

   // surrogate bases
   localparam logic [15:0] SurrHiBase = 16'hD800;
   localparam logic [15:0] SurrLoBase = 16'hDC00;
   localparam logic [20:0] SuppBase   = 21'h10000;

   // what the body of one job expands to
   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_LIT,
      KIND_ESC,
      KIND_HEX,
      KIND_HEX2,
      KIND_RAW,
      KIND_ERR
   } jse_kind_type;

   // one classified item: optional quotes around one body
   typedef struct packed {
      logic         open;
      logic         close;
      jse_kind_type kind;
      logic [2:0]   nraw;
      logic [31:0]  data;
   } jse_job_type;

   // queue status toward front and back
   typedef struct packed {
      logic full;
      logic nonempty;
   } jse_qstat_type;

   // uppercase hex digit
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = 8'h30 + {4'h0, nib};
      end else begin
         c = 8'h37 + {4'h0, nib};
      end
      return c;
   endfunction

   // second character of a short escape, zero if none
   function automatic logic [7:0] short_escape(input logic [7:0] b);
      logic [7:0] e;
      case (b)
         8'h22: e = 8'h22;
         8'h5C: e = 8'h5C;
         8'h08: e = 8'h62;
         8'h0C: e = 8'h66;
         8'h0A: e = 8'h6E;
         8'h0D: e = 8'h72;
         8'h09: e = 8'h74;
         default: e = 8'h00;
      endcase
      return e;
   endfunction

endpackage

// ===== design/jse_if.sv =====
interface jse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] str_byte;
   logic       starts_string;
   logic       ends_string;
   logic       empty_string;

   modport source(output valid, str_byte, starts_string, ends_string, empty_string,
                  input ready);
   modport sink(input valid, str_byte, starts_string, ends_string, empty_string,
                output ready);
endinterface

interface jse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       run_last;
   logic       malformed;

   modport source(output valid, out_char, run_last, malformed, input ready);
   modport sink(input valid, out_char, run_last, malformed, output ready);
endinterface

// ===== design/json_string_escaper.sv =====
// channel   dir  handshake          payload
// req       in   valid/ready        str_byte, starts_string, ends_string, empty_string
// rsp       out  valid/ready        out_char, run_last, malformed
// csr       in   csr_wr_en (no ack) csr_wr_data = escape non-ascii as \u hex
//
// a byte is classified in the cycle it is taken and queued as at most one job; the
// serializer then gives one character per cycle while rsp is ready, so a job expands
// to 1 character for plain text, up to 13 for a surrogate pair and the closing quote.
// input keeps flowing at one byte per cycle until the 4-entry job queue fills.
// reset is synchronous and clears decoder state, queue and output valid.
// rsp holds while ready is low; a stalled output stalls input only through the queue.
module json_string_escaper (
   input  logic      clock,
   input  logic      reset,
   jse_req_if.sink   req,
   jse_rsp_if.source rsp,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data
);

   logic                   push;
   logic                   pop;
   jse_pkg::jse_job_type   push_job;
   jse_pkg::jse_job_type   head_job;
   jse_pkg::jse_qstat_type qstat;

   // classifier and utf-8 decoder
   jse_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .qstat       (qstat),
      .push        (push),
      .push_job    (push_job)
   );

   // job queue
   jse_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .qstat    (qstat)
   );

   // character serializer
   jse_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .qstat    (qstat),
      .pop      (pop),
      .rsp      (rsp)
   );

endmodule

// ===== design/jse_front.sv =====
module jse_front (
   input  logic                 clock,
   input  logic                 reset,
   jse_req_if.sink              req,
   input  logic                 csr_wr_en,
   input  logic                 csr_wr_data,
   input  jse_pkg::jse_qstat_type qstat,
   output logic                 push,
   output jse_pkg::jse_job_type push_job
);

   logic        unicode_esc_ff;
   logic [20:0] cp_ff, cp_in;
   logic [1:0]  expect_ff, expect_in;
   logic [23:0] held_ff, held_in;
   logic [1:0]  held_cnt_ff, held_cnt_in;
   logic        discard_ff, discard_in;

   logic                 take;
   jse_pkg::jse_job_type job;
   logic                 emit;

   assign req.ready = !qstat.full;
   assign take      = req.valid && req.ready;
   assign push      = take && emit;
   assign push_job  = job;

   // decode one transfer against the pending sequence
   always_comb begin
      logic [7:0]  b;
      logic [7:0]  esc;
      logic        bad;
      logic [20:0] cp_c;
      logic [1:0]  exp_c;
      logic [23:0] held_c;
      logic [1:0]  cnt_c;
      logic [20:0] adj;
      logic [15:0] hi;
      logic [15:0] lo;

      b           = req.str_byte;
      esc         = 8'h00;
      bad         = 1'b0;
      job         = '0;
      job.kind    = jse_pkg::KIND_NONE;
      emit        = 1'b0;
      cp_in       = cp_ff;
      expect_in   = expect_ff;
      held_in     = held_ff;
      held_cnt_in = held_cnt_ff;
      discard_in  = discard_ff;
      cp_c        = cp_ff;
      exp_c       = expect_ff;
      held_c      = held_ff;
      cnt_c       = held_cnt_ff;
      adj         = '0;
      hi          = '0;
      lo          = '0;

      if (take) begin
         if (req.empty_string) begin
            job.open    = 1'b1;
            job.close   = 1'b1;
            emit        = 1'b1;
            cp_in       = '0;
            expect_in   = '0;
            held_in     = '0;
            held_cnt_in = '0;
            discard_in  = 1'b0;
         end else if (!req.starts_string && discard_ff) begin
            if (req.ends_string) begin
               discard_in = 1'b0;
            end
         end else begin
            // a new string drops whatever was pending
            if (req.starts_string) begin
               job.open   = 1'b1;
               cp_c       = '0;
               exp_c      = '0;
               held_c     = '0;
               cnt_c      = '0;
               discard_in = 1'b0;
            end
            cp_in       = cp_c;
            expect_in   = exp_c;
            held_in     = held_c;
            held_cnt_in = cnt_c;

            if (exp_c != 2'd0) begin
               // continuation byte
               if (b[7:6] != 2'b10) begin
                  bad = 1'b1;
               end else begin
                  cp_in     = {cp_c[14:0], b[5:0]};
                  expect_in = exp_c - 2'd1;
                  if (expect_in == 2'd0) begin
                     if (!unicode_esc_ff) begin
                        job.kind = jse_pkg::KIND_RAW;
                        job.nraw = {1'b0, cnt_c} + 3'd1;
                        job.data = {held_c, b} << {2'(2'd3 - cnt_c), 3'b000};
                     end else if (cp_in[20:16] == 5'd0) begin
                        job.kind = jse_pkg::KIND_HEX;
                        job.data = {cp_in[15:0], 16'h0000};
                     end else begin
                        adj      = cp_in - jse_pkg::SuppBase;
                        hi       = jse_pkg::SurrHiBase + {5'b0, adj[20:10]};
                        lo       = jse_pkg::SurrLoBase + {6'b0, adj[9:0]};
                        job.kind = jse_pkg::KIND_HEX2;
                        job.data = {hi, lo};
                     end
                     cp_in       = '0;
                     held_in     = '0;
                     held_cnt_in = '0;
                  end else begin
                     held_in     = {held_c[15:0], b};
                     held_cnt_in = cnt_c + 2'd1;
                  end
               end
            end else begin
               // plain byte or lead byte
               esc = jse_pkg::short_escape(b);
               if (esc != 8'h00) begin
                  job.kind      = jse_pkg::KIND_ESC;
                  job.data[7:0] = esc;
               end else if (b < 8'h20) begin
                  job.kind = jse_pkg::KIND_HEX;
                  job.data = {8'h00, b, 16'h0000};
               end else if (b < 8'h80) begin
                  job.kind      = jse_pkg::KIND_LIT;
                  job.data[7:0] = b;
               end else if (b[7:5] == 3'b110) begin
                  expect_in   = 2'd1;
                  cp_in       = {16'h0, b[4:0]};
                  held_in     = {16'h0, b};
                  held_cnt_in = 2'd1;
               end else if (b[7:4] == 4'b1110) begin
                  expect_in   = 2'd2;
                  cp_in       = {17'h0, b[3:0]};
                  held_in     = {16'h0, b};
                  held_cnt_in = 2'd1;
               end else if (b[7:3] == 5'b11110) begin
                  expect_in   = 2'd3;
                  cp_in       = {18'h0, b[2:0]};
                  held_in     = {16'h0, b};
                  held_cnt_in = 2'd1;
               end else begin
                  bad = 1'b1;
               end
            end

            // truncated sequence at end of string
            if (!bad && req.ends_string && expect_in != 2'd0) begin
               bad = 1'b1;
            end

            if (bad) begin
               job.kind    = jse_pkg::KIND_ERR;
               job.data    = '0;
               job.nraw    = '0;
               cp_in       = '0;
               expect_in   = '0;
               held_in     = '0;
               held_cnt_in = '0;
               discard_in  = !req.ends_string;
            end else begin
               job.close = req.ends_string;
            end
            emit = job.open || job.close || (job.kind != jse_pkg::KIND_NONE);
         end
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         cp_ff       <= '0;
         expect_ff   <= '0;
         held_ff     <= '0;
         held_cnt_ff <= '0;
         discard_ff  <= 1'b0;
      end else begin
         cp_ff       <= cp_in;
         expect_ff   <= expect_in;
         held_ff     <= held_in;
         held_cnt_ff <= held_cnt_in;
         discard_ff  <= discard_in;
      end
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         unicode_esc_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unicode_esc_ff <= csr_wr_data;
      end
   end

   // a discard never coexists with a pending sequence
   a_discard_no_pending: assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> (expect_ff == 2'd0))
      else $error("discard with pending sequence");

   // pending sequence always holds its lead byte
   a_pending_held: assert property (@(posedge clock) disable iff (reset)
      (expect_ff != 2'd0) |-> (held_cnt_ff != 2'd0) && (expect_ff + held_cnt_ff <= 3'd4))
      else $error("pending sequence byte count inconsistent");

endmodule

// ===== design/jse_queue.sv =====
module jse_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  jse_pkg::jse_job_type   push_job,
   input  logic                   pop,
   output jse_pkg::jse_job_type   head_job,
   output jse_pkg::jse_qstat_type qstat
);

   jse_pkg::jse_job_type                  slot_ff [jse_pkg::QueueDepth];
   logic [jse_pkg::QueuePtrW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [jse_pkg::QueuePtrW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [jse_pkg::QueueCntW-1:0]         cnt_ff, cnt_in;

   assign head_job       = slot_ff[rd_ptr_ff];
   assign qstat.full     = (cnt_ff == jse_pkg::QueueCntW'(jse_pkg::QueueDepth));
   assign qstat.nonempty = (cnt_ff != '0);

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + {{(jse_pkg::QueueCntW-1){1'b0}}, push}
                         - {{(jse_pkg::QueueCntW-1){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!qstat.full || pop))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> qstat.nonempty)
      else $error("queue underflow");

endmodule

// ===== design/jse_back.sv =====
module jse_back (
   input  logic                   clock,
   input  logic                   reset,
   input  jse_pkg::jse_job_type   head_job,
   input  jse_pkg::jse_qstat_type qstat,
   output logic                   pop,
   jse_rsp_if.source              rsp
);

   logic [3:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       malformed_ff, malformed_in;

   logic       load;
   logic [3:0] body_len;
   logic [3:0] job_len;

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_char  = char_ff;
   assign rsp.run_last  = last_ff;
   assign rsp.malformed = malformed_ff;

   assign load = qstat.nonempty && (!rsp_valid_ff || rsp.ready);

   // character count of the head job
   always_comb begin
      case (head_job.kind)
         jse_pkg::KIND_NONE: body_len = 4'd0;
         jse_pkg::KIND_LIT:  body_len = 4'd1;
         jse_pkg::KIND_ESC:  body_len = 4'd2;
         jse_pkg::KIND_HEX:  body_len = 4'd6;
         jse_pkg::KIND_HEX2: body_len = 4'd12;
         jse_pkg::KIND_RAW:  body_len = {1'b0, head_job.nraw};
         jse_pkg::KIND_ERR:  body_len = 4'd1;
         default:            body_len = 4'd0;
      endcase
      job_len = body_len + {3'b0, head_job.open} + {3'b0, head_job.close};
   end

   // pick the character at the current position
   always_comb begin
      logic [3:0]  j;
      logic [3:0]  k;
      logic [15:0] word;
      logic [7:0]  body_char;

      j         = idx_ff - {3'b0, head_job.open};
      k         = (j >= 4'd6) ? j - 4'd6 : j;
      word      = (j >= 4'd6) ? head_job.data[15:0] : head_job.data[31:16];
      body_char = 8'h00;

      case (head_job.kind)
         jse_pkg::KIND_LIT: body_char = head_job.data[7:0];
         jse_pkg::KIND_ESC: body_char = (j == 4'd0) ? jse_pkg::CharBslash
                                                     : head_job.data[7:0];
         jse_pkg::KIND_RAW: body_char = 8'(head_job.data >> {2'(2'd3 - j[1:0]), 3'b000});
         jse_pkg::KIND_HEX, jse_pkg::KIND_HEX2: begin
            case (k)
               4'd0:    body_char = jse_pkg::CharBslash;
               4'd1:    body_char = jse_pkg::CharLowerU;
               4'd2:    body_char = jse_pkg::hex_char(word[15:12]);
               4'd3:    body_char = jse_pkg::hex_char(word[11:8]);
               4'd4:    body_char = jse_pkg::hex_char(word[7:4]);
               default: body_char = jse_pkg::hex_char(word[3:0]);
            endcase
         end
         default: body_char = 8'h00;
      endcase

      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      malformed_in = malformed_ff;
      idx_in       = idx_ff;
      pop          = 1'b0;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         malformed_in = 1'b0;
         if (head_job.open && idx_ff == 4'd0) begin
            char_in = jse_pkg::CharQuote;
         end else if (j < body_len) begin
            char_in      = body_char;
            malformed_in = (head_job.kind == jse_pkg::KIND_ERR);
         end else begin
            char_in = jse_pkg::CharQuote;
         end
         last_in = (idx_ff == job_len - 4'd1);
         if (last_in) begin
            pop    = 1'b1;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   // output register and position counter
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      last_ff      <= last_in;
      malformed_ff <= malformed_in;
   end

   // an error ends the run of results for its transfer
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && malformed_ff) |-> last_ff)
      else $error("error result not last of its run");

   // the position never runs past the head job
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      qstat.nonempty |-> (idx_ff < job_len))
      else $error("serializer position beyond job length");

endmodule
